[hw/rtl/plane_segment_cut_bounds_core_macros.svh]
// assertion macros used by the rtl top level
`ifndef PLANE_SEGMENT_CUT_BOUNDS_CORE_MACROS_SVH
`define PLANE_SEGMENT_CUT_BOUNDS_CORE_MACROS_SVH

// same-cycle implication
`define PSCB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pscb assertion failed");

// next-cycle implication
`define PSCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pscb assertion failed");

`endif

[hw/rtl/pscb_pkg.sv]
package pscb_pkg;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 48;

  localparam logic [CfgIdxWidth-1:0] CFG_ORIGIN_X       = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ORIGIN_Y       = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ORIGIN_Z       = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_PLANE_NORMAL   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_AXIS_U         = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_AXIS_V         = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_PARALLEL_LIMIT = 3'd6;

  localparam logic signed [31:0] BOX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] BOX_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    MUL_UN,
    MUL_VN,
    MUL_HI,
    MUL_LO,
    MUL_AXU,
    MUL_AXV
  } mul_op_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_op_t    mul_op;
    logic [1:0] lane;
    logic       first;
    logic       last;
    logic       div_init;
    logic       div_step;
    logic       div_first;
    logic       box_update;
    logic       emit;
  } pscb_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_seg;
    logic out_free;
  } pscb_status_t;

  function automatic logic signed [15:0] vec_field(input logic [47:0] packed_vec,
                                                   input logic [1:0] k);
    logic signed [15:0] f;
    case (k)
      2'd0: f = signed'(packed_vec[15:0]);
      2'd1: f = signed'(packed_vec[31:16]);
      default: f = signed'(packed_vec[47:32]);
    endcase
    return f;
  endfunction

endpackage

[hw/rtl/pscb_ctrl.sv]
module pscb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pscb_pkg::pscb_status_t status,
  output pscb_pkg::pscb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_CHECK,
    S_DIV,
    S_SCALE,
    S_PROJ,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic [5:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt + 6'd1;
    cmd = '0;
    cmd.mul_op = pscb_pkg::MUL_UN;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DOT;
        end
      end
      S_DOT: begin
        if (cnt < 6'd6) begin
          cmd.mul_en = 1'b1;
          cmd.mul_op = (cnt < 6'd3) ? pscb_pkg::MUL_UN : pscb_pkg::MUL_VN;
          case (cnt)
            6'd0, 6'd3: cmd.lane = 2'd0;
            6'd1, 6'd4: cmd.lane = 2'd1;
            default: cmd.lane = 2'd2;
          endcase
          cmd.first = (cmd.lane == 2'd0);
          cmd.last = (cmd.lane == 2'd2);
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (status.skip) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_first = (cnt == 6'd0);
        if (cnt == 6'd32) begin
          cnt_next = '0;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = cnt[0] ? pscb_pkg::MUL_LO : pscb_pkg::MUL_HI;
        cmd.lane = cnt[2:1];
        if (cnt == 6'd5) begin
          cnt_next = '0;
          state_next = S_PROJ;
        end
      end
      S_PROJ: begin
        if (cnt < 6'd6) begin
          cmd.mul_en = 1'b1;
          cmd.mul_op = (cnt < 6'd3) ? pscb_pkg::MUL_AXU : pscb_pkg::MUL_AXV;
          case (cnt)
            6'd0, 6'd3: cmd.lane = 2'd0;
            6'd1, 6'd4: cmd.lane = 2'd1;
            default: cmd.lane = 2'd2;
          endcase
          cmd.first = (cmd.lane == 2'd0);
          cmd.last = (cmd.lane == 2'd2);
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.box_update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!status.last_seg) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule

[hw/rtl/pscb_datapath.sv]
module pscb_datapath #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pscb_pkg::pscb_cmd_t                    cmd,
  output pscb_pkg::pscb_status_t                 status,
  input  logic                                   cfg_valid,
  input  logic [pscb_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [pscb_pkg::CfgDataWidth-1:0]      cfg_data,
  input  logic signed [COORD_WIDTH-1:0]          start_x,
  input  logic signed [COORD_WIDTH-1:0]          start_y,
  input  logic signed [COORD_WIDTH-1:0]          start_z,
  input  logic signed [COORD_WIDTH-1:0]          end_x,
  input  logic signed [COORD_WIDTH-1:0]          end_y,
  input  logic signed [COORD_WIDTH-1:0]          end_z,
  input  logic                                   last_segment,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [31:0]                     bound_min_u,
  output logic signed [31:0]                     bound_min_v,
  output logic signed [31:0]                     bound_max_u,
  output logic signed [31:0]                     bound_max_v,
  output logic                                   any_hit
);

  localparam int CwEff = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  function automatic logic signed [31:0] ext(input logic [COORD_WIDTH-1:0] x);
    logic signed [CwEff-1:0] lo;
    lo = signed'(x[CwEff-1:0]);
    return 32'(lo);
  endfunction

  // configuration
  logic signed [31:0] origin [3];
  logic [47:0] plane_normal, axis_u, axis_v;
  logic [15:0] parallel_limit;

  // item
  logic signed [32:0] op_r [3];
  logic signed [32:0] d_r [3];
  logic signed [34:0] rel [3];
  logic last_r;

  // arithmetic
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] prod;
  logic tag_valid, tag_first, tag_last;
  pscb_pkg::mul_op_t tag_op;
  logic [1:0] tag_lane;
  logic signed [54:0] acc, acc_next;
  logic signed [54:0] u_r, v_r;
  logic [50:0] h_r;
  logic signed [31:0] cu;

  // divider
  logic [54:0] au, av, av_r;
  logic [55:0] rem, rem_sh;
  logic [32:0] t;
  logic div_bit;

  // box
  logic signed [31:0] run_min_u, run_min_v, run_max_u, run_max_v;
  logic hit_seen;

  logic [32:0] ad;
  logic [51:0] s_sum;
  logic signed [34:0] s_val;
  logic signed [40:0] shifted;

  always_comb begin
    ad = d_r[cmd.lane][32] ? 33'(-d_r[cmd.lane]) : 33'(d_r[cmd.lane]);
    case (cmd.mul_op)
      pscb_pkg::MUL_UN: begin
        mul_a = 35'(op_r[cmd.lane]);
        mul_b = 18'(pscb_pkg::vec_field(plane_normal, cmd.lane));
      end
      pscb_pkg::MUL_VN: begin
        mul_a = 35'(d_r[cmd.lane]);
        mul_b = 18'(pscb_pkg::vec_field(plane_normal, cmd.lane));
      end
      pscb_pkg::MUL_HI: begin
        mul_a = signed'({2'b00, ad});
        mul_b = signed'({1'b0, t[32:16]});
      end
      pscb_pkg::MUL_LO: begin
        mul_a = signed'({2'b00, ad});
        mul_b = signed'({2'b00, t[15:0]});
      end
      pscb_pkg::MUL_AXU: begin
        mul_a = rel[cmd.lane];
        mul_b = 18'(pscb_pkg::vec_field(axis_u, cmd.lane));
      end
      default: begin
        mul_a = rel[cmd.lane];
        mul_b = 18'(pscb_pkg::vec_field(axis_v, cmd.lane));
      end
    endcase
  end

  always_comb begin
    acc_next = tag_first ? 55'(prod) : acc + 55'(prod);
    shifted = 41'(acc_next >>> 14);
    if (shifted > 41'sd2147483647) begin
      cu = pscb_pkg::BOX_MAX;
    end else if (shifted < -41'sd2147483648) begin
      cu = pscb_pkg::BOX_MIN;
    end else begin
      cu = 32'(shifted);
    end
    s_sum = 52'(h_r) + 52'(prod[50:16]);
    s_val = signed'({2'b00, s_sum[48:16]});
  end

  always_comb begin
    au = u_r[54] ? 55'(-u_r) : 55'(u_r);
    av = v_r[54] ? 55'(-v_r) : 55'(v_r);
    status.skip = (v_r == '0) || (av < {25'd0, parallel_limit, 14'd0})
                  || ((u_r != '0) && (u_r[54] != v_r[54])) || (au > av);
    status.last_seg = last_r;
    status.out_free = !out_valid || !out_stall;
    rem_sh = cmd.div_first ? rem : {rem[54:0], 1'b0};
    div_bit = (rem_sh >= {1'b0, av_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      plane_normal <= 48'h4000_0000_0000;
      axis_u <= 48'h0000_0000_4000;
      axis_v <= 48'h0000_4000_0000;
      parallel_limit <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pscb_pkg::CFG_ORIGIN_X: origin[0] <= signed'(cfg_data[31:0]);
        pscb_pkg::CFG_ORIGIN_Y: origin[1] <= signed'(cfg_data[31:0]);
        pscb_pkg::CFG_ORIGIN_Z: origin[2] <= signed'(cfg_data[31:0]);
        pscb_pkg::CFG_PLANE_NORMAL: plane_normal <= cfg_data;
        pscb_pkg::CFG_AXIS_U: axis_u <= cfg_data;
        pscb_pkg::CFG_AXIS_V: axis_v <= cfg_data;
        pscb_pkg::CFG_PARALLEL_LIMIT: parallel_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r[0] <= 33'(origin[0]) - 33'(ext(start_x));
      op_r[1] <= 33'(origin[1]) - 33'(ext(start_y));
      op_r[2] <= 33'(origin[2]) - 33'(ext(start_z));
      d_r[0] <= 33'(ext(end_x)) - 33'(ext(start_x));
      d_r[1] <= 33'(ext(end_y)) - 33'(ext(start_y));
      d_r[2] <= 33'(ext(end_z)) - 33'(ext(start_z));
      last_r <= last_segment;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    tag_op <= cmd.mul_op;
    tag_lane <= cmd.lane;
    tag_first <= cmd.first;
    tag_last <= cmd.last;
    if (tag_valid) begin
      case (tag_op)
        pscb_pkg::MUL_HI: h_r <= prod[50:0];
        pscb_pkg::MUL_LO: begin
          rel[tag_lane] <= -35'(op_r[tag_lane])
                           + (d_r[tag_lane][32] ? -s_val : s_val);
        end
        default: begin
          acc <= acc_next;
          if (tag_last) begin
            case (tag_op)
              pscb_pkg::MUL_UN: u_r <= acc_next;
              pscb_pkg::MUL_VN: v_r <= acc_next;
              default: ;
            endcase
          end
        end
      endcase
    end
    if (cmd.div_init) begin
      rem <= {1'b0, au};
      av_r <= av;
      t <= '0;
    end else if (cmd.div_step) begin
      rem <= div_bit ? rem_sh - {1'b0, av_r} : rem_sh;
      t <= {t[31:0], div_bit};
    end
  end

  // projected coordinates, saturated
  logic signed [31:0] cu_r, cv_r;

  always_ff @(posedge clk) begin
    if (tag_valid && tag_last && (tag_op == pscb_pkg::MUL_AXU)) begin
      cu_r <= cu;
    end
    if (tag_valid && tag_last && (tag_op == pscb_pkg::MUL_AXV)) begin
      cv_r <= cu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
      run_min_u <= pscb_pkg::BOX_MAX;
      run_min_v <= pscb_pkg::BOX_MAX;
      run_max_u <= pscb_pkg::BOX_MIN;
      run_max_v <= pscb_pkg::BOX_MIN;
      hit_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tag_valid <= cmd.mul_en;
      if (cmd.emit) begin
        run_min_u <= pscb_pkg::BOX_MAX;
        run_min_v <= pscb_pkg::BOX_MAX;
        run_max_u <= pscb_pkg::BOX_MIN;
        run_max_v <= pscb_pkg::BOX_MIN;
        hit_seen <= 1'b0;
      end else if (cmd.box_update) begin
        if (cu_r < run_min_u) run_min_u <= cu_r;
        if (cv_r < run_min_v) run_min_v <= cv_r;
        if (cu_r > run_max_u) run_max_u <= cu_r;
        if (cv_r > run_max_v) run_max_v <= cv_r;
        hit_seen <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bound_min_u <= run_min_u;
      bound_min_v <= run_min_v;
      bound_max_u <= run_max_u;
      bound_max_v <= run_max_v;
      any_hit <= hit_seen;
    end
  end

endmodule

[hw/rtl/plane_segment_cut_bounds_core.sv]
// channel   dir  handshake                payload
// in        in   in_valid / in_stall      start_*, end_*, last_segment
// out       out  out_valid / out_stall    bound_min_*, bound_max_*, any_hit
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one request at a time; each segment uses the shared 35x18 multiplier, and
// one that cuts the plane also the 33-step restoring divider; one that is
// skipped leaves out the divider
// a result waits in the output register; a last segment that finds it still
// stalled holds in_stall until it is taken
// rst is synchronous: configuration returns to its reset values, box cleared
`include "plane_segment_cut_bounds_core_macros.svh"

module plane_segment_cut_bounds_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     start_x,
  input  logic signed [COORD_WIDTH-1:0]     start_y,
  input  logic signed [COORD_WIDTH-1:0]     start_z,
  input  logic signed [COORD_WIDTH-1:0]     end_x,
  input  logic signed [COORD_WIDTH-1:0]     end_y,
  input  logic signed [COORD_WIDTH-1:0]     end_z,
  input  logic                              last_segment,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                bound_min_u,
  output logic signed [31:0]                bound_min_v,
  output logic signed [31:0]                bound_max_u,
  output logic signed [31:0]                bound_max_v,
  output logic                              any_hit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pscb_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [pscb_pkg::CfgDataWidth-1:0] cfg_data
);

  pscb_pkg::pscb_cmd_t cmd;
  pscb_pkg::pscb_status_t status;

  assign cfg_ready = 1'b1;

  pscb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pscb_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .last_segment (last_segment),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .bound_min_u  (bound_min_u),
    .bound_min_v  (bound_min_v),
    .bound_max_u  (bound_max_u),
    .bound_max_v  (bound_max_v),
    .any_hit      (any_hit)
  );

  `PSCB_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `PSCB_ASSERT_NOW(a_empty_box, clk, rst, out_valid && !any_hit,
    bound_min_u == pscb_pkg::BOX_MAX && bound_max_v == pscb_pkg::BOX_MIN)
  `PSCB_ASSERT_NOW(a_box_ordered, clk, rst, out_valid && any_hit,
    bound_min_u <= bound_max_u && bound_min_v <= bound_max_v)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

class bound_scoreboard;
  logic signed [31:0] exp_min_u[$];
  logic signed [31:0] exp_min_v[$];
  logic signed [31:0] exp_max_u[$];
  logic signed [31:0] exp_max_v[$];
  logic exp_hit[$];
  int errors;

  logic signed [31:0] org_x, org_y, org_z;
  logic [47:0] nrm, ax_u, ax_v;
  logic [15:0] par_lim;
  longint box_min_u, box_min_v, box_max_u, box_max_v;
  bit box_hit;

  function void clear_box();
    box_min_u = 64'sd2147483647;
    box_min_v = 64'sd2147483647;
    box_max_u = -64'sd2147483648;
    box_max_v = -64'sd2147483648;
    box_hit = 0;
  endfunction

  function void reset_cfg();
    org_x = 0;
    org_y = 0;
    org_z = 0;
    nrm = 48'h1 << 46;
    ax_u = 48'h1 << 14;
    ax_v = 48'h1 << 30;
    par_lim = 1;
    clear_box();
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] data);
    case (idx)
      pscb_pkg::CFG_ORIGIN_X: org_x = data[31:0];
      pscb_pkg::CFG_ORIGIN_Y: org_y = data[31:0];
      pscb_pkg::CFG_ORIGIN_Z: org_z = data[31:0];
      pscb_pkg::CFG_PLANE_NORMAL: nrm = data;
      pscb_pkg::CFG_AXIS_U: ax_u = data;
      pscb_pkg::CFG_AXIS_V: ax_v = data;
      pscb_pkg::CFG_PARALLEL_LIMIT: par_lim = data[15:0];
      default: ;
    endcase
  endfunction

  function longint lane(logic [47:0] pk, int k);
    logic signed [15:0] f;
    f = pk[16*k +: 16];
    return longint'(f);
  endfunction

  function longint dot(longint a0, longint a1, longint a2, logic [47:0] pk);
    return a0 * lane(pk, 0) + a1 * lane(pk, 1) + a2 * lane(pk, 2);
  endfunction

  function longint floor14sat(longint x);
    longint r;
    r = x >>> 14;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function longint scale(longint d, logic [63:0] t);
    logic [63:0] ad, hi, lo;
    longint s;
    ad = d < 0 ? -d : d;
    hi = ad * (t >> 16);
    lo = ad * (t & 64'hffff);
    s = longint'((hi + (lo >> 16)) >> 16);
    return d < 0 ? -s : s;
  endfunction

  function void note_segment(logic signed [31:0] px, py, pz, qx, qy, qz, logic last);
    longint op[3], d[3], rel[3];
    longint u, v, cu, cv;
    logic [63:0] au, av, r, t;
    bit counts;
    op[0] = longint'(org_x) - px; op[1] = longint'(org_y) - py;
    op[2] = longint'(org_z) - pz;
    d[0] = longint'(qx) - px; d[1] = longint'(qy) - py; d[2] = longint'(qz) - pz;
    u = dot(op[0], op[1], op[2], nrm);
    v = dot(d[0], d[1], d[2], nrm);
    au = u < 0 ? -u : u;
    av = v < 0 ? -v : v;
    counts = !(v == 0 || av < (64'(par_lim) << 14));
    if (u != 0 && ((u < 0) != (v < 0))) counts = 0;
    if (au > av) counts = 0;
    if (counts) begin
      r = au;
      t = 0;
      if (r >= av) begin t = 1; r -= av; end
      for (int k = 0; k < 32; k++) begin
        r <<= 1;
        t <<= 1;
        if (r >= av) begin r -= av; t |= 1; end
      end
      for (int k = 0; k < 3; k++) rel[k] = -op[k] + scale(d[k], t);
      cu = floor14sat(dot(rel[0], rel[1], rel[2], ax_u));
      cv = floor14sat(dot(rel[0], rel[1], rel[2], ax_v));
      if (cu < box_min_u) box_min_u = cu;
      if (cv < box_min_v) box_min_v = cv;
      if (cu > box_max_u) box_max_u = cu;
      if (cv > box_max_v) box_max_v = cv;
      box_hit = 1;
    end
    if (last) begin
      exp_min_u.push_back(box_min_u[31:0]);
      exp_min_v.push_back(box_min_v[31:0]);
      exp_max_u.push_back(box_max_u[31:0]);
      exp_max_v.push_back(box_max_v[31:0]);
      exp_hit.push_back(box_hit);
      clear_box();
    end
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task check_box(logic signed [31:0] mnu, mnv, mxu, mxv, logic hit);
    if (exp_hit.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    if (mnu !== exp_min_u[0]) report("bound_min_u", mnu, exp_min_u[0]);
    if (mnv !== exp_min_v[0]) report("bound_min_v", mnv, exp_min_v[0]);
    if (mxu !== exp_max_u[0]) report("bound_max_u", mxu, exp_max_u[0]);
    if (mxv !== exp_max_v[0]) report("bound_max_v", mxv, exp_max_v[0]);
    if (hit !== exp_hit[0]) report("any_hit", hit, exp_hit[0]);
    void'(exp_min_u.pop_front());
    void'(exp_min_v.pop_front());
    void'(exp_max_u.pop_front());
    void'(exp_max_v.pop_front());
    void'(exp_hit.pop_front());
  endtask
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] start_x = 0, start_y = 0, start_z = 0;
  logic signed [31:0] end_x = 0, end_y = 0, end_z = 0;
  logic last_segment = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] bound_min_u, bound_min_v, bound_max_u, bound_max_v;
  logic any_hit;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [47:0] cfg_data = 0;

  bound_scoreboard sb;
  int cycles = 0;
  int hold_off = 0;

  plane_segment_cut_bounds_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 80);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall, one long hold-off
  initial begin
    int g;
    @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off = hold_off - 1;
      end else begin
        g = $urandom_range(0, 9);
        out_stall <= (g < 3);
      end
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_box(bound_min_u, bound_min_v, bound_max_u, bound_max_v, any_hit);
    end
  end

  // cfg_valid drops when the next request starts
  task automatic write_cfg(logic [2:0] idx, logic [47:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // in_valid stays high into a back-to-back request
  task automatic send_segment(logic signed [31:0] px, py, pz, qx, qy, qz, logic last,
                              bit nogap);
    int g;
    g = nogap ? 0 : gap_len();
    cfg_valid <= 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    start_x <= px; start_y <= py; start_z <= pz;
    end_x <= qx; end_y <= qy; end_z <= qz;
    last_segment <= last;
    do @(posedge clk); while (in_stall);
    sb.note_segment(px, py, pz, qx, qy, qz, last);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_hit.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  function logic [47:0] rnd_vec();
    logic [47:0] v;
    int m;
    m = $urandom_range(0, 3);
    if (m == 0) v = 48'({$urandom, $urandom});
    else begin
      v = 0;
      v[16*$urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
      if (m == 3) v[16*$urandom_range(0, 2) +: 16] = 16'($urandom);
    end
    return v;
  endfunction

  task automatic rand_phase(int n, int mode);
    logic signed [31:0] pz;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      pz = rnd_coord(mode);
      if (k < 7)
        send_segment(rnd_coord(mode), rnd_coord(mode), pz, rnd_coord(mode),
                     rnd_coord(mode), -pz + rnd_coord(2), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 4) == 0);
      else
        send_segment(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                     rnd_coord(0), rnd_coord(0), $urandom_range(0, 3) == 0, 0);
    end
    send_segment(0, 0, 0, 0, 0, 0, 1, 0);
    drain();
  endtask

  task automatic rand_cfg();
    write_cfg(pscb_pkg::CFG_ORIGIN_X, {16'h0, rnd_coord(2)});
    write_cfg(pscb_pkg::CFG_ORIGIN_Y, {16'h0, rnd_coord(2)});
    write_cfg(pscb_pkg::CFG_ORIGIN_Z, {16'h0, rnd_coord(2)});
    write_cfg(pscb_pkg::CFG_PLANE_NORMAL, rnd_vec());
    write_cfg(pscb_pkg::CFG_AXIS_U, rnd_vec());
    write_cfg(pscb_pkg::CFG_AXIS_V, rnd_vec());
    write_cfg(pscb_pkg::CFG_PARALLEL_LIMIT,
              48'($urandom_range(0, 3) == 0 ? $urandom : 1));
  endtask

  initial begin
    sb = new();
    sb.reset_cfg();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset config, crossing, miss, parallel, extremes, empty set
    send_segment(0, 0, -32'sh10000, 32'sh10000, 32'sh20000, 32'sh10000, 0, 1);
    send_segment(32'sh30000, -32'sh10000, 32'sh10000, 0, 0, -32'sh30000, 0, 0);
    send_segment(0, 0, 32'sh10000, 0, 0, 32'sh20000, 0, 0);
    send_segment(5, 5, 7, 9, 9, 7, 0, 0);
    send_segment(0, 0, 0, 0, 0, 0, 0, 0);
    send_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1, 0);
    send_segment(0, 0, 32'sh10000, 0, 0, 32'sh20000, 1, 0);
    send_segment(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1, 0);
    send_segment(0, 0, 0, 1, 1, 1, 1, 0);
    send_segment(32'shffffffff, 32'shffffffff, 32'shffffffff, 0, 0, 0, 1, 0);
    drain();
    write_cfg(pscb_pkg::CFG_PARALLEL_LIMIT, 0);
    write_cfg(3'd7, 48'hffff_ffff_ffff);
    send_segment(0, 0, 0, 0, 0, 0, 0, 0);
    send_segment(0, 0, -1, 0, 0, 1, 1, 0);
    drain();
    write_cfg(pscb_pkg::CFG_ORIGIN_X, 48'h7fffffff);
    write_cfg(pscb_pkg::CFG_ORIGIN_Y, 48'h80000000);
    write_cfg(pscb_pkg::CFG_ORIGIN_Z, 48'hffffffff);
    write_cfg(pscb_pkg::CFG_PLANE_NORMAL, 48'h7fff_8000_7fff);
    write_cfg(pscb_pkg::CFG_AXIS_U, 48'h8000_8000_8000);
    write_cfg(pscb_pkg::CFG_AXIS_V, 48'h7fff_7fff_7fff);
    write_cfg(pscb_pkg::CFG_PARALLEL_LIMIT, 48'hffff);
    send_segment(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1, 0);
    drain();

    // long receiver hold-off while segments keep coming
    hold_off = 600;
    rand_phase(20, 1);
    rand_cfg();
    rand_phase(60, 1);

    for (int ph = 0; ph < 6; ph++) begin
      rand_cfg();
      rand_phase(60, ph % 3);
    end
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pscb_pkg.sv
hw/rtl/pscb_ctrl.sv
hw/rtl/pscb_datapath.sv
hw/rtl/plane_segment_cut_bounds_core.sv
dv/testbench.sv
